@@ rtl/sorted_insertion_buffer_top_macros.svh @@
// Assertion macros shared by the sorted insertion buffer RTL.
`ifndef SORTED_INSERTION_BUFFER_TOP_MACROS_SVH
`define SORTED_INSERTION_BUFFER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define SIB_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Check that a condition implies another in the next cycle.
`define SIB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define SIB_ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define SIB_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

@@ rtl/sib_pkg.sv @@
// Shared widths, constants and types of the sorted insertion buffer.
package sib_pkg;
   localparam int SIB_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int RANK_W       = 4;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [RANK_W-1:0]         rank_type;

   // Tag of one store read on its way to the result queue.
   typedef struct packed {
      logic     valid;
      rank_type rank;
      logic     last;
      logic     full;
   } sib_issue_type;

   // One result beat.
   typedef struct packed {
      value_type value;
      rank_type  rank;
      logic      last;
      logic      full;
   } sib_beat_type;
endpackage

@@ rtl/sib_if.sv @@
// Valid/ready channel interfaces for the input samples and the sorted results.
interface sib_req_if;
   logic                valid;
   logic                ready;
   sib_pkg::value_type  sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface sib_rsp_if;
   logic                valid;
   logic                ready;
   sib_pkg::value_type  sorted_value;
   sib_pkg::rank_type   rank;
   logic                last_of_run;
   logic                store_full;

   modport source (output valid, output sorted_value, output rank,
                   output last_of_run, output store_full, input ready);
   modport sink   (input valid, input sorted_value, input rank,
                   input last_of_run, input store_full, output ready);
endinterface

@@ rtl/sib_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sib_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/sib_ctrl.sv @@
// Sequencer: insertion walk over the store RAM and read-out of the sorted run.
`include "sorted_insertion_buffer_top_macros.svh"
module sib_ctrl #(
   parameter int CAPACITY = sib_pkg::SIB_CAPACITY,
   localparam int ADDR_W = $clog2(CAPACITY),
   localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   sib_req_if.sink                req_bus,
   output sib_pkg::sib_issue_type issue,
   input  logic                   can_issue,
   output logic                   ram_wr_en,
   output logic [ADDR_W-1:0]      ram_wr_addr,
   output sib_pkg::value_type     ram_wr_data,
   output logic                   ram_rd_en,
   output logic [ADDR_W-1:0]      ram_rd_addr,
   input  sib_pkg::value_type     ram_rd_data
);
   import sib_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCMP = 2'd1;
   localparam logic [1:0] S_SKEY = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              full_ff, full_in;
   value_type         key_ff, key_in;
   logic              accept;
   logic              store_full;
   logic              k_last;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign store_full    = (count_ff == CNT_W'(CAPACITY));
   assign k_last        = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      full_in     = full_ff;
      key_in      = key_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = key_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff - ADDR_W'(1);
      issue       = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in  = req_bus.sample_value;
               full_in = store_full;
               k_in    = '0;
               pos_in  = ADDR_W'(count_ff);
               if (store_full) begin
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  state_in = S_SKEY;
               end else begin
                  // fetch the current top entry to start the walk
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(count_ff - CNT_W'(1));
                  state_in    = S_SCMP;
               end
            end
         end
         S_SCMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data > key_ff) begin
               // move the larger entry up and fetch the one below
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = S_SKEY;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = pos_ff - ADDR_W'(2);
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_EMIT;
            end
         end
         S_SKEY: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            ram_rd_addr = k_ff;
            if (can_issue) begin
               ram_rd_en   = 1'b1;
               issue.valid = 1'b1;
               issue.rank  = RANK_W'(k_ff);
               issue.last  = k_last;
               issue.full  = full_ff;
               if (k_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      full_ff <= full_in;
      key_ff  <= key_in;
   end

   `SIB_ASSERT_IMPLY(a_rw_distinct, clock, reset, ram_wr_en && ram_rd_en,
                     ram_wr_addr != ram_rd_addr, "read and write hit the same entry")
   `SIB_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
                     count_ff <= CNT_W'(CAPACITY), "entry count beyond capacity")
   `SIB_ASSERT_NEXT(a_last_idle, clock, reset, issue.valid && issue.last,
                    state_ff == S_IDLE, "run did not end after its last beat")
endmodule

@@ rtl/sib_outq.sv @@
// Two-entry result queue fed by store reads, with issue credit.
`include "sorted_insertion_buffer_top_macros.svh"
module sib_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  sib_pkg::sib_issue_type issue,
   output logic                   can_issue,
   input  sib_pkg::value_type     ram_rd_data,
   sib_rsp_if.source              rsp_bus
);
   import sib_pkg::*;

   sib_issue_type tag_ff;
   sib_beat_type  head_ff, head_in;
   sib_beat_type  skid_ff, skid_in;
   sib_beat_type  new_beat;
   logic [1:0]    occ_ff, occ_in;
   logic          pop;
   logic          push;
   logic [2:0]    occ_after;

   assign pop  = (occ_ff != 2'd0) && rsp_bus.ready;
   assign push = tag_ff.valid;

   assign new_beat.value = ram_rd_data;
   assign new_beat.rank  = tag_ff.rank;
   assign new_beat.last  = tag_ff.last;
   assign new_beat.full  = tag_ff.full;

   // a read issued now lands next cycle; leave room for it
   assign occ_after = 3'(occ_ff) + 3'(push) - 3'(pop);
   assign can_issue = (occ_after <= 3'd1);

   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      occ_in  = occ_ff;
      case (occ_ff)
         2'd0: begin
            if (push) begin
               head_in = new_beat;
               occ_in  = 2'd1;
            end
         end
         2'd1: begin
            if (pop && push) begin
               head_in = new_beat;
            end else if (pop) begin
               occ_in = 2'd0;
            end else if (push) begin
               skid_in = new_beat;
               occ_in  = 2'd2;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = skid_ff;
               if (push) begin
                  skid_in = new_beat;
               end else begin
                  occ_in = 2'd1;
               end
            end
         end
         default: begin
            occ_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
         occ_ff <= 2'd0;
      end else begin
         tag_ff <= issue;
         occ_ff <= occ_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid        = (occ_ff != 2'd0);
   assign rsp_bus.sorted_value = head_ff.value;
   assign rsp_bus.rank         = head_ff.rank;
   assign rsp_bus.last_of_run  = head_ff.last;
   assign rsp_bus.store_full   = head_ff.full;

   `SIB_ASSERT_IMPLY(a_no_overflow, clock, reset, push && (occ_ff == 2'd2),
                     pop, "result queue overflow")
   `SIB_ASSERT_IMPLY(a_credit, clock, reset, issue.valid,
                     can_issue, "read issued without queue room")
endmodule

@@ rtl/sorted_insertion_buffer_top.sv @@
// Top level of the sorted insertion buffer.
// The block keeps up to CAPACITY signed 16.16 values in ascending order in
// one store RAM (one write and one registered read port). Each sample beat
// on req_bus is inserted at its ordered place, after any equal entries;
// when the store is already full the sample is dropped. After every sample
// the whole store goes out on rsp_bus in ascending order, one beat per
// entry, with rank, last_of_run on the final beat and store_full on every
// beat of a run whose sample was dropped. An item is accepted in the idle
// state, then takes the insertion walk down past every entry larger than
// the sample, then reads out all entries while rsp_bus keeps taking beats.
// A dropped sample skips the walk. The walk and the read-out both go through
// the single RAM read port, one entry a cycle, the read-out only while the
// result queue has room. A two-beat result queue decouples the RAM read
// from rsp_bus stalls. The store needs no clearing after reset: only
// entries below the count are ever read.
module sorted_insertion_buffer_top #(
   parameter int CAPACITY = sib_pkg::SIB_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   sib_req_if.sink   req_bus,
   sib_rsp_if.source rsp_bus
);
   import sib_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);

   sib_issue_type     issue;
   logic              can_issue;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   value_type         ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_raw;
   value_type         ram_rd_data;

   assign ram_rd_data = value_type'(ram_rd_raw);

   // sequence the insertion walk and the read-out
   sib_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .issue       (issue),
      .can_issue   (can_issue),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // hold the sorted entries
   sib_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // queue result beats toward rsp_bus
   sib_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .can_issue   (can_issue),
      .ram_rd_data (ram_rd_data),
      .rsp_bus     (rsp_bus)
   );
endmodule

@@ sim/sorted_insertion_buffer_checker.sv @@
// Result checker for the sorted insertion buffer: tracks the sorted store and compares every beat.
`timescale 1ns / 1ps

module sorted_insertion_buffer_checker #(
   parameter int CAPACITY = sib_pkg::SIB_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  sib_pkg::value_type  req_sample_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  sib_pkg::value_type  rsp_sorted_value,
   input  sib_pkg::rank_type   rsp_rank,
   input  logic                rsp_last_of_run,
   input  logic                rsp_store_full,
   output int                  fail_count,
   output int                  pending_beats
);
   import sib_pkg::*;

   value_type    ordered_store [CAPACITY];
   int unsigned  stored_count;
   int           mismatches;
   sib_beat_type sorted_run_q [$];

   // Insert one sample (unless full) and queue the whole sorted run it causes.
   task automatic insert_and_list(input value_type sample);
      int unsigned  slot;
      bit           is_full;
      sib_beat_type beat;
      is_full = (stored_count >= CAPACITY);
      if (!is_full) begin
         slot = stored_count;
         // shift larger entries up; equal entries stay ahead of the sample
         while (slot > 0 && ordered_store[slot-1] > sample) begin
            ordered_store[slot] = ordered_store[slot-1];
            slot--;
         end
         ordered_store[slot] = sample;
         stored_count++;
      end
      for (int k = 0; k < stored_count; k++) begin
         beat.value = ordered_store[k];
         beat.rank  = rank_type'(k);
         beat.last  = (k + 1 == stored_count);
         beat.full  = is_full;
         sorted_run_q.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      sib_beat_type want;
      if (reset) begin
         sorted_run_q.delete();
         stored_count = 0;
         mismatches   = 0;
      end else begin
         // check the result beat first: a sample taken on this edge cannot
         // have produced it
         if (rsp_valid && rsp_ready) begin
            if (sorted_run_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat value=%h rank=%0d last=%b full=%b", $time,
                        rsp_sorted_value, rsp_rank, rsp_last_of_run, rsp_store_full);
            end else begin
               want = sorted_run_q.pop_front();
               if (rsp_sorted_value !== want.value || rsp_rank !== want.rank ||
                   rsp_last_of_run !== want.last || rsp_store_full !== want.full) begin
                  mismatches++;
                  $display("%0t: mismatch expected value=%h rank=%0d last=%b full=%b",
                           $time, want.value, want.rank, want.last, want.full);
                  $display("%0t:          actual   value=%h rank=%0d last=%b full=%b",
                           $time, rsp_sorted_value, rsp_rank, rsp_last_of_run,
                           rsp_store_full);
               end
            end
         end
         if (req_valid && req_ready)
            insert_and_list(req_sample_value);
      end
      fail_count    <= mismatches;
      pending_beats <= sorted_run_q.size();
   end

endmodule

@@ sim/sorted_insertion_buffer_top_test.sv @@
// Testbench top for the sorted insertion buffer: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module sorted_insertion_buffer_top_test;
   import sib_pkg::*;

   localparam int SETTLE_CYCLES  = 2 * SIB_CAPACITY + 8;
   localparam int WATCHDOG_LIMIT = 5000;                  // cycles with no beat on either side
   localparam int RANDOM_ITEMS   = 150;
   localparam int HOLD_AFTER     = 600;                   // result beats before the long hold
   localparam int HOLD_CYCLES    = 300;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_beats;
   int   idle_cycles;

   sib_req_if req_bus ();
   sib_rsp_if rsp_bus ();

   sorted_insertion_buffer_top #(.CAPACITY(SIB_CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   sorted_insertion_buffer_checker #(.CAPACITY(SIB_CAPACITY)) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_sample_value (req_bus.sample_value),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_sorted_value (rsp_bus.sorted_value),
      .rsp_rank         (rsp_bus.rank),
      .rsp_last_of_run  (rsp_bus.last_of_run),
      .rsp_store_full   (rsp_bus.store_full),
      .fail_count       (fail_count),
      .pending_beats    (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one sample beat and hold it until the block takes it. Random
   // idle cycles go in front unless the caller wants a gap-free stream.
   // Valid is left high on return so back-to-back beats need no toggle.
   task automatic send_sample(input value_type sample, input bit steady);
      if (!steady) begin
         while ($urandom_range(99) < 26) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.sample_value <= sample;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // Drop valid and wait until every queued result beat has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0)
         @(posedge clock);
   endtask

   // Directed part: fills the store with extremes, duplicates and mixed
   // signs, then keeps going so the full-store rejection shows up.
   value_type directed_samples [20] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_8000,
      32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002,
      // store is full from here on
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h1234_5678
   };

   // Stimulus and verdict.
   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.sample_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_samples[i])
         send_sample(directed_samples[i], 1'b0);

      // let the sender pause until the directed runs have fully drained
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // pause once more mid-stream until nothing is outstanding
         if (i == 40)
            wait_drained();
         // items 70..109 go out back to back with no sender gaps
         send_sample(value_type'($urandom), (i >= 70 && i < 110));
      end
      req_bus.valid <= 1'b0;

      while (pending_beats != 0)
         @(posedge clock);
      // give the block time to push out any stray beats
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_beats == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Result side: random stalls, one long hold-off once the sender is busy
   // so the block backs up into its input, and a stretch of steady ready.
   initial begin
      int beats_taken;
      int hold_left;
      bit hold_done;
      beats_taken = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            beats_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (beats_taken >= 1200 && beats_taken < 1800) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 26);
         end
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
